@@ src/darm_pkg.sv @@
`timescale 1ns / 1ps
package darm_pkg;

  localparam int unsigned CfgWidth = 32;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [CfgIdxWidth-1:0] REG_WIN_LOW_MODE   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_WIN_LOW_VALUE  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_WIN_HIGH_MODE  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_WIN_HIGH_VALUE = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_ENTRIES_IN_USE = 3'd4;

  localparam logic [1:0] BOUND_NONE      = 2'd0;
  localparam logic [1:0] BOUND_INCLUSIVE = 2'd1;
  localparam logic [1:0] BOUND_EXCLUSIVE = 2'd2;
  localparam logic [1:0] BOUND_RESERVED  = 2'd3;

  localparam logic [1:0] KIND_CLEAR    = 2'd0;
  localparam logic [1:0] KIND_SIGMA    = 2'd1;
  localparam logic [1:0] KIND_ABS      = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

  typedef struct packed {
    logic               command;
    logic [2:0]         entry_slot;
    logic [1:0]         entry_kind;
    logic [1:0]         entry_bound_mode;
    logic signed [31:0] entry_bound;
    logic [7:0]         entry_severity;
    logic signed [31:0] current;
    logic signed [31:0] mean;
    logic signed [31:0] spread;
  } req_t;

  typedef struct packed {
    logic        in_range;
    logic        matched;
    logic [2:0]  match_slot;
    logic [7:0]  match_severity;
    logic [30:0] deviation;
  } rsp_t;

  // One range table entry as stored in memory.
  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         mode;
    logic signed [31:0] bound;
    logic [7:0]         severity;
  } entry_t;

  // Lower-bound test on a wide signed value.
  function automatic logic passes_lower(input logic [1:0] mode,
                                        input logic signed [49:0] value,
                                        input logic signed [31:0] bound);
    logic signed [49:0] b;
    logic r;
    begin
      b = 50'(bound);
      unique case (mode)
        BOUND_NONE:      r = 1'b1;
        BOUND_INCLUSIVE: r = value >= b;
        BOUND_EXCLUSIVE: r = value > b;
        default:         r = 1'b0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ src/deviation_alarm_rule_matcher_core.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Handshake         | Payload
// req      | in        | req_valid/ready   | darm_pkg::req_t
// rsp      | out       | rsp_valid/ready   | darm_pkg::rsp_t
// cfg      | in        | cfg_we            | cfg_index, cfg_data
//
// A write is committed as it is accepted, and writes may follow back to back.
// A sample request runs the window check and difference, then a bit-serial
// divide of a 56-bit dividend (with an extra setup step when the mean is
// the divisor), then a walk that reads one table entry per cycle. A sample
// outside the window skips the divide and the walk. When spread and mean
// are both near zero the divide is skipped.
// Reset (rst, synchronous) clears control state and the configuration
// registers; the table holds nothing meaningful until written. The result sits
// in an output register; a stalled result holds the block until it is taken.
module deviation_alarm_rule_matcher_core #(
  parameter int unsigned TABLE_DEPTH   = 8,
  parameter int unsigned NEAR_ZERO_Q16 = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  darm_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output darm_pkg::rsp_t                      rsp,
  input  logic                                cfg_we,
  input  logic [darm_pkg::CfgIdxWidth-1:0]    cfg_index,
  input  logic [darm_pkg::CfgWidth-1:0]       cfg_data
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [2:0] {S_IDLE, S_SCORE, S_DIV, S_WALK, S_OUT} state_t;

  state_t state;

  // Configuration registers.
  logic [1:0]         win_low_mode, win_high_mode;
  logic signed [31:0] win_low_value, win_high_value;
  logic [3:0]         entries_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_low_mode <= '0;
      win_low_value <= '0;
      win_high_mode <= '0;
      win_high_value <= '0;
      entries_in_use <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        darm_pkg::REG_WIN_LOW_MODE:   win_low_mode <= cfg_data[1:0];
        darm_pkg::REG_WIN_LOW_VALUE:  win_low_value <= cfg_data;
        darm_pkg::REG_WIN_HIGH_MODE:  win_high_mode <= cfg_data[1:0];
        darm_pkg::REG_WIN_HIGH_VALUE: win_high_value <= cfg_data;
        darm_pkg::REG_ENTRIES_IN_USE: entries_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Number of entries walked, clamped to the table depth.
  logic [6:0] walk_len;
  always_comb begin
    if (7'(entries_in_use) > 7'(TABLE_DEPTH)) walk_len = 7'(TABLE_DEPTH);
    else walk_len = 7'(entries_in_use);
  end

  // Table RAM. Writes come from write requests; reads are driven by the walk.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  darm_pkg::entry_t  ram_wdata, ram_rdata;
  logic [43:0]       ram_rbits;

  darm_ram #(.Width(44), .Depth(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );
  assign ram_rdata = darm_pkg::entry_t'(ram_rbits);

  // A write request is accepted in IDLE and committed in the same edge; the
  // slot check filters slots that lie beyond the table.
  logic req_fire;
  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign ram_we    = req_fire && (req.command == darm_pkg::CMD_WRITE) &&
                     (32'(req.entry_slot) < 32'(TABLE_DEPTH));
  assign ram_waddr = AW'(req.entry_slot);
  assign ram_wdata = '{kind: req.entry_kind, mode: req.entry_bound_mode,
                       bound: req.entry_bound, severity: req.entry_severity};

  // Sample registers.
  logic signed [31:0] cur, mn, sp;
  logic [32:0]        diff;         // |cur - mean|
  logic signed [49:0] score;
  logic [6:0]         walk_idx;     // index of the entry being read
  logic [6:0]         chk_idx;      // index of entry whose data is on rdata
  logic               chk_valid;

  // Window check and case selection on the stored sample.
  logic signed [32:0] dsgn;
  logic [31:0] smag, mmag;
  logic        low_fail, high_fail;
  logic        sp_big, mn_big;
  logic signed [42:0] zscore;
  logic [42:0] zmag;

  always_comb begin
    dsgn = 33'(cur) - 33'(mn);
    smag = sp[31] ? 32'(-33'(sp)) : 32'(sp);
    mmag = mn[31] ? 32'(-33'(mn)) : 32'(mn);
    sp_big = smag > 32'(NEAR_ZERO_Q16);
    mn_big = mmag > 32'(NEAR_ZERO_Q16);
    low_fail  = (win_low_mode == darm_pkg::BOUND_INCLUSIVE && cur < win_low_value) ||
                (win_low_mode == darm_pkg::BOUND_EXCLUSIVE && cur <= win_low_value);
    high_fail = (win_high_mode == darm_pkg::BOUND_INCLUSIVE && cur > win_high_value) ||
                (win_high_mode == darm_pkg::BOUND_EXCLUSIVE && cur >= win_high_value);
    zscore = 43'sd65536 + 43'(cur) * 43'sd1000;
    zmag = zscore[42] ? 43'(-zscore) : zscore;
  end

  // Divider. Dividend is d<<16 for the sigma case, (100*d)<<16 otherwise.
  logic        div_start, div_done;
  logic [55:0] div_dividend, div_q;
  logic [31:0] div_divisor;
  logic [39:0] d100;

  assign d100 = 40'(diff) * 40'd100;

  darm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Divider operands, registered in S_SCORE (the mean-case dividend in S_DIV).
  logic [55:0] dividend_r;
  logic [31:0] divisor_r;
  assign div_dividend = dividend_r;
  assign div_divisor  = divisor_r;
  logic div_go;
  assign div_start = div_go;

  // Walk logic: value compared for the entry on rdata.
  logic signed [49:0] entry_val;
  logic               entry_hit;
  always_comb begin
    entry_val = (ram_rdata.kind == darm_pkg::KIND_SIGMA) ? score : 50'(diff);
    entry_hit = chk_valid &&
                (ram_rdata.kind == darm_pkg::KIND_SIGMA ||
                 ram_rdata.kind == darm_pkg::KIND_ABS) &&
                darm_pkg::passes_lower(ram_rdata.mode, entry_val, ram_rdata.bound);
  end
  assign ram_raddr = AW'(walk_idx);

  function automatic logic [30:0] sat(input logic signed [49:0] v);
    return (v > 50'sd2147483647) ? darm_pkg::SAT31 : v[30:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
      div_go <= 1'b0;
      chk_valid <= 1'b0;
      walk_idx <= '0;
      chk_idx <= '0;
    end else begin
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_fire && req.command == darm_pkg::CMD_EVAL) begin
            cur <= req.current;
            mn <= req.mean;
            sp <= req.spread;
            state <= S_SCORE;
          end
        end
        S_SCORE: begin
          diff <= dsgn[32] ? 33'(-dsgn) : 33'(dsgn);
          walk_idx <= '0;
          chk_valid <= 1'b0;
          if (low_fail || high_fail) begin
            rsp <= '0;
            rsp_valid <= 1'b1;
            state <= S_OUT;
          end else if (sp_big) begin
            dividend_r <= {8'h0, 32'(dsgn[32] ? 33'(-dsgn) : 33'(dsgn)), 16'h0};
            divisor_r <= smag;
            div_go <= 1'b1;
            state <= S_DIV;
          end else if (mn_big) begin
            // 100*d is formed from the registered diff in the next cycle, in S_DIV.
            divisor_r <= mmag;
            dividend_r <= '0;
            state <= S_DIV;
            div_go <= 1'b0;
            chk_idx <= 7'h7F;  // marks the mean case for the next cycle
          end else begin
            score <= 50'(zmag);
            state <= S_WALK;
          end
        end
        S_DIV: begin
          if (chk_idx == 7'h7F) begin
            dividend_r <= {1'b0, d100[38:0], 16'h0};
            div_go <= 1'b1;
            chk_idx <= '0;
          end else if (div_done) begin
            // A quotient of 2^49 or more passes every bound and saturates, so
            // it is held at 2^31, which behaves the same.
            score <= (div_q[55:49] != '0) ? 50'sd2147483648 : 50'(div_q);
            state <= S_WALK;
          end
        end
        S_WALK: begin
          // Address issued this cycle, data checked next cycle.
          if (entry_hit) begin
            rsp <= '{in_range: 1'b1, matched: 1'b1, match_slot: 3'(chk_idx),
                     match_severity: ram_rdata.severity, deviation: sat(entry_val)};
            rsp_valid <= 1'b1;
            chk_valid <= 1'b0;
            state <= S_OUT;
          end else if (walk_idx >= walk_len) begin
            if (!chk_valid || walk_idx == walk_len) begin
              rsp <= '{in_range: 1'b1, matched: 1'b0, match_slot: 3'd0,
                       match_severity: 8'd0, deviation: sat(score)};
              rsp_valid <= 1'b1;
              chk_valid <= 1'b0;
              state <= S_OUT;
            end
          end else begin
            chk_idx <= walk_idx;
            chk_valid <= 1'b1;
            walk_idx <= walk_idx + 7'd1;
          end
        end
        S_OUT: begin
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req_ready) else $error("request taken while busy");
  a_rsp_only_out: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (state == S_OUT)) else $error("response outside output state");
  a_rejected_clear: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.in_range) |-> (!rsp.matched && rsp.deviation == '0))
    else $error("out-of-window result not cleared");
`endif
endmodule

@@ src/darm_ram.sv @@
`timescale 1ns / 1ps
module darm_ram #(
  parameter int unsigned Width = 44,
  parameter int unsigned Depth = 8
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                              wdata,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                              rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/darm_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. 56-bit dividend, 32-bit divisor.
module darm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [55:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [55:0] quotient
);
  logic [5:0]  count;
  logic        busy;
  logic [32:0] rem;
  logic [33:0] trial;

  assign trial = {rem, quotient[55]} - {2'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd55;
        rem <= '0;
        quotient <= dividend;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          quotient <= {quotient[54:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quotient[55]};
          quotient <= {quotient[54:0], 1'b0};
        end
        if (count == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count - 6'd1;
      end
    end
  end
endmodule
